/* sv/swa_pkg.sv */
// ----------------------------------------------------------------------------
// swa_pkg
// Shared types, constants and helpers for the sliding window average queue.
// ----------------------------------------------------------------------------
package swa_pkg;

    localparam int MAX_DEPTH   = 256;
    localparam int ADDR_W      = $clog2(MAX_DEPTH);
    localparam int CNT_W       = $clog2(MAX_DEPTH + 1);
    localparam int SAMPLE_W    = 32;
    localparam int SUM_W       = SAMPLE_W + ADDR_W;
    localparam int WIN_W       = 9;
    localparam int FILL_W      = 9;
    localparam int LEN_W       = (CNT_W > WIN_W) ? CNT_W : WIN_W;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 80;

    localparam logic [WIN_W-1:0]   WIN_RESET   = WIN_W'(16);
    localparam logic [PADDR_W-1:0] REG_WINDOW  = PADDR_W'(0);

    localparam logic CMD_PUSH   = 1'b0;
    localparam logic CMD_POP    = 1'b1;
    localparam logic STAT_OK    = 1'b0;
    localparam logic STAT_EMPTY = 1'b1;

    // one classified request, handed from the front to the back
    typedef struct packed {
        logic                push;
        logic                drop;    // oldest sample leaves the ring
        logic                err;     // pop on empty ring
        logic [ADDR_W-1:0]   rd_addr;
        logic [ADDR_W-1:0]   wr_addr;
        logic [SAMPLE_W-1:0] sample;
        logic [CNT_W-1:0]    count;   // fill count after this request
    } t_op;

    function automatic logic [CNT_W-1:0] active_len(input logic [WIN_W-1:0] win);
        logic [LEN_W-1:0] w;
        w = LEN_W'(win);
        if (w == '0) begin
            return CNT_W'(1);
        end else if (w > LEN_W'(MAX_DEPTH)) begin
            return CNT_W'(MAX_DEPTH);
        end else begin
            return CNT_W'(w);
        end
    endfunction

    function automatic logic [ADDR_W-1:0] next_idx(input logic [ADDR_W-1:0] idx,
                                                   input logic [CNT_W-1:0]  len);
        logic [CNT_W-1:0] inc;
        inc = CNT_W'(idx) + CNT_W'(1);
        return (inc >= len) ? '0 : ADDR_W'(inc);
    endfunction

    function automatic logic signed [SUM_W-1:0] sext_sample(input logic [SAMPLE_W-1:0] v);
        return {{(SUM_W - SAMPLE_W){v[SAMPLE_W-1]}}, v};
    endfunction

endpackage

/* sv/swa_fifo.sv */
// ----------------------------------------------------------------------------
// swa_fifo
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
module swa_fifo import swa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_op  o_data
);

    t_op                r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wptr;
    logic [QPTR_W-1:0]  r_rptr;
    logic [QCNT_W-1:0]  r_cnt;

    logic wr_en;
    logic rd_en;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_slot[r_rptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (wr_en) begin
                r_wptr <= (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + QPTR_W'(1);
            end
            if (rd_en) begin
                r_rptr <= (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + QPTR_W'(1);
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_slot[r_wptr] <= i_data;
        end
    end

endmodule

/* sv/swa_front.sv */
// ----------------------------------------------------------------------------
// swa_front
// Accepts requests, tracks ring indices and fill count, classifies each one.
// ----------------------------------------------------------------------------
module swa_front import swa_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_clear,
    input  logic [WIN_W-1:0]    i_win,
    input  logic                i_valid,
    input  logic                i_cmd,
    input  logic [SAMPLE_W-1:0] i_sample,
    output logic                o_ready,
    input  logic                i_q_full,
    output logic                o_q_push,
    output t_op                 o_q_data
);

    logic [ADDR_W-1:0] r_rd_idx, n_rd_idx;
    logic [ADDR_W-1:0] r_wr_idx, n_wr_idx;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  len;
    logic              full;
    logic              empty;
    logic              accept;
    t_op               op;

    assign o_ready  = !i_q_full;
    assign accept   = i_valid && !i_q_full;
    assign o_q_push = accept;
    assign o_q_data = op;

    always_comb begin
        len        = active_len(i_win);
        full       = (r_count >= len);
        empty      = (r_count == '0);
        op.push    = (i_cmd == CMD_PUSH);
        op.sample  = i_sample;
        op.rd_addr = r_rd_idx;
        op.wr_addr = r_wr_idx;
        if (i_cmd == CMD_PUSH) begin
            // full ring: the oldest sample is overwritten
            op.drop  = full;
            op.err   = 1'b0;
            op.count = full ? r_count : r_count + CNT_W'(1);
            n_wr_idx = next_idx(r_wr_idx, len);
            n_rd_idx = full ? next_idx(r_rd_idx, len) : r_rd_idx;
        end else begin
            op.drop  = !empty;
            op.err   = empty;
            op.count = empty ? r_count : r_count - CNT_W'(1);
            n_wr_idx = r_wr_idx;
            n_rd_idx = empty ? r_rd_idx : next_idx(r_rd_idx, len);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_rd_idx <= '0;
            r_wr_idx <= '0;
            r_count  <= '0;
        end else if (accept) begin
            r_rd_idx <= n_rd_idx;
            r_wr_idx <= n_wr_idx;
            r_count  <= op.count;
        end
    end

endmodule

/* sv/swa_div.sv */
// ----------------------------------------------------------------------------
// swa_div
// Bit-serial signed-by-unsigned divider, one quotient bit per cycle,
// truncating toward zero.
// ----------------------------------------------------------------------------
module swa_div import swa_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [SUM_W-1:0] i_dividend,
    input  logic [CNT_W-1:0]        i_divisor,
    output logic                    o_done,
    output logic [SUM_W-1:0]        o_quotient
);

    localparam int STEP_W = $clog2(SUM_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [SUM_W-1:0]  r_acc;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_dvs;
    logic              r_neg;

    logic [CNT_W:0]    trial;
    logic              qbit;

    assign trial      = {r_rem, r_acc[SUM_W-1]};
    assign qbit       = (trial >= {1'b0, r_dvs});
    assign o_done     = r_done;
    assign o_quotient = r_neg ? (~r_acc + SUM_W'(1)) : r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(SUM_W - 1);
            end else if (r_busy) begin
                r_step <= r_step - STEP_W'(1);
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend shifts out the top while quotient bits enter at the bottom;
    // the remainder stays below the divisor, so it fits the divisor width
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[SUM_W-1];
            r_acc <= i_dividend[SUM_W-1] ? (~i_dividend + SUM_W'(1)) : i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= qbit ? CNT_W'(trial - {1'b0, r_dvs}) : trial[CNT_W-1:0];
            r_acc <= {r_acc[SUM_W-2:0], qbit};
        end
    end

endmodule

/* sv/swa_back.sv */
// ----------------------------------------------------------------------------
// swa_back
// Executes queued requests: sample memory, running sum, average, result reg.
// ----------------------------------------------------------------------------
module swa_back import swa_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_clear,
    input  logic                i_q_valid,
    input  t_op                 i_q_data,
    output logic                o_q_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_status,
    output logic [SAMPLE_W-1:0] o_popped,
    output logic [SAMPLE_W-1:0] o_average,
    output logic [CNT_W-1:0]    o_count
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]              r_state, n_state;
    t_op                     r_op;
    logic [SAMPLE_W-1:0]     r_mem [MAX_DEPTH];
    logic [SAMPLE_W-1:0]     r_rd_data;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic                    r_status;
    logic [SAMPLE_W-1:0]     r_popped;
    logic [SAMPLE_W-1:0]     r_avg;
    logic [CNT_W-1:0]        r_count;

    logic signed [SUM_W-1:0] old_val;
    logic signed [SUM_W-1:0] new_val;
    logic                    div_start;
    logic                    div_done;
    logic [SUM_W-1:0]        div_quot;

    assign o_q_pop   = (r_state == ST_IDLE) && i_q_valid;
    assign o_valid   = (r_state == ST_OUT);
    assign o_status  = r_status;
    assign o_popped  = r_popped;
    assign o_average = r_avg;
    assign o_count   = r_count;

    always_comb begin
        old_val   = r_op.drop ? sext_sample(r_rd_data) : '0;
        new_val   = r_op.push ? sext_sample(r_op.sample) : '0;
        n_sum     = r_sum - old_val + new_val;
        div_start = (r_state == ST_EXEC) && (r_op.count != '0);
        n_state   = r_state;
        unique case (r_state)
            ST_IDLE: if (i_q_valid) n_state = ST_EXEC;
            ST_EXEC: n_state = div_start ? ST_DIV : ST_OUT;
            ST_DIV:  if (div_done) n_state = ST_OUT;
            ST_OUT:  if (i_ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sum   <= '0;
        end else begin
            r_state <= n_state;
            if (i_clear) begin
                r_sum <= '0;
            end else if (r_state == ST_EXEC) begin
                r_sum <= n_sum;
            end
        end
    end

    // sample memory, registered read of the oldest entry
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_q_data.rd_addr];
        if (r_state == ST_EXEC && r_op.push) begin
            r_mem[r_op.wr_addr] <= r_op.sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_op <= i_q_data;
        end
        if (r_state == ST_EXEC) begin
            r_status <= r_op.err;
            r_popped <= (!r_op.push && r_op.drop) ? r_rd_data : '0;
            r_count  <= r_op.count;
            r_avg    <= '0;
        end else if (r_state == ST_DIV && div_done) begin
            r_avg <= div_quot[SAMPLE_W-1:0];
        end
    end

    swa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (n_sum),
        .i_divisor  (r_op.count),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

endmodule

/* sv/sliding_window_average_queue_unit.sv */
// ----------------------------------------------------------------------------
// The back works on one request at a time and takes no new one until its result
// is taken. The bit-serial divider (one quotient bit per cycle over the 40-bit
// sum) runs for each result; a result on an empty ring skips it. The front
// keeps taking requests into a 2-deep queue.
// Reset (synchronous, active low) empties the ring, clears the sum and sets
// window_length to 16; a window_length write empties the ring the same way.
// ----------------------------------------------------------------------------
// sliding_window_average_queue_unit
// Moving-average ring buffer in signed Q16.16 with stream ports and APB config.
// ----------------------------------------------------------------------------
module sliding_window_average_queue_unit import swa_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // request stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [31:0] sample
    input  logic [0:0]             s_tuser,   // [0] cmd
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [31:0] popped_value, [63:32] average,
                                              // [72:64] fill_count, [79:73] zero
    output logic [0:0]             m_tuser,   // [0] status
    // configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [PDATA_W-1:0]     pwdata,
    output logic [PDATA_W-1:0]     prdata,
    output logic                   pready
);

    logic [WIN_W-1:0]    r_win;
    logic                cfg_wr;
    logic                q_full;
    logic                q_push;
    t_op                 q_wdata;
    logic                q_pop;
    logic                q_valid;
    t_op                 q_rdata;
    logic                res_status;
    logic [SAMPLE_W-1:0] res_popped;
    logic [SAMPLE_W-1:0] res_avg;
    logic [CNT_W-1:0]    res_count;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == REG_WINDOW);
    assign prdata = (paddr == REG_WINDOW) ? PDATA_W'(r_win) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= WIN_RESET;
        end else if (cfg_wr) begin
            r_win <= pwdata[WIN_W-1:0];
        end
    end

    swa_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (cfg_wr),
        .i_win    (r_win),
        .i_valid  (s_tvalid),
        .i_cmd    (s_tuser[0]),
        .i_sample (s_tdata[SAMPLE_W-1:0]),
        .o_ready  (s_tready),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_data (q_wdata)
    );

    swa_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    swa_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (cfg_wr),
        .i_q_valid (q_valid),
        .i_q_data  (q_rdata),
        .o_q_pop   (q_pop),
        .o_valid   (m_tvalid),
        .i_ready   (m_tready),
        .o_status  (res_status),
        .o_popped  (res_popped),
        .o_average (res_avg),
        .o_count   (res_count)
    );

    assign m_tuser = res_status;
    assign m_tdata = {(OUT_TDATA_W - FILL_W - 2 * SAMPLE_W)'(0), FILL_W'(res_count),
                      res_avg, res_popped};

    // an empty-ring pop reports nothing removed and an empty ring
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && res_status == STAT_EMPTY) |->
            (res_count == '0 && res_popped == '0 && res_avg == '0))
        else $error("empty pop result carries data");

    // average is zero whenever the ring is empty
    a_empty_avg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && res_count == '0) |-> (res_avg == '0))
        else $error("nonzero average on empty ring");

    // fill count never exceeds the ring depth
    a_fill_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (res_count <= CNT_W'(MAX_DEPTH)))
        else $error("fill count beyond ring depth");

endmodule

/* test/sliding_window_average_queue_unit_test.sv */
// ----------------------------------------------------------------------------
// sliding_window_average_queue_unit_test
// Self-checking bench for the moving-average ring: a directed table walks the
// value extremes, pops on an empty ring, overwrites of a full ring, truncation
// of negative averages and window writes of 0 and above the depth; random
// push/pop traffic then runs over several window settings with gaps and stalls
// on both streams. Results are checked against table rows or a local ring predictor.
// ----------------------------------------------------------------------------
module sliding_window_average_queue_unit_test;
    import swa_pkg::*;

    localparam int RUN_LIMIT  = 4_000_000;
    localparam int SETTLE     = 60;    // a bit over the block's latency
    localparam int LONG_HOLD  = 400;
    localparam int NUM_ROWS   = 26;
    localparam int NUM_PHASES = 8;

    typedef struct packed {
        logic                status;
        logic [SAMPLE_W-1:0] popped;
        logic [SAMPLE_W-1:0] average;
        logic [FILL_W-1:0]   fill;
    } t_result;

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;

    // for ROW_CFG rows, sample carries the window_length value
    typedef struct packed {
        t_row_kind           kind;
        logic                cmd;
        logic [SAMPLE_W-1:0] sample;
        logic                typed;
        t_result             want;
    } t_dir_row;

    typedef struct {
        logic [PDATA_W-1:0] window;
        int                 items;
        int                 push_pct;
        bit                 idle;
        bit                 squeeze;
    } t_phase;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;   // [31:0] sample
    logic [0:0]             s_tuser;   // [0] cmd
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // [31:0] popped_value, [63:32] average,
                                       // [72:64] fill_count, [79:73] zero
    logic [0:0]             m_tuser;   // [0] status
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_W-1:0]     paddr;
    logic [PDATA_W-1:0]     pwdata;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    sliding_window_average_queue_unit i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // ring predictor state
    logic signed [SAMPLE_W-1:0] ring_mem [MAX_DEPTH];
    int                         ring_rd;
    int                         ring_wr;
    int                         ring_cnt;
    longint                     ring_sum;
    logic [WIN_W-1:0]           ring_win;

    t_result pending_results [$];

    int  fail_count;
    int  n_push;
    int  n_pop;
    int  n_empty_pop;
    int  n_overwrite;
    int  n_windows;
    bit  idle_on;
    int  hold_asked;
    int  hold_done;

    t_dir_row directed_rows [NUM_ROWS] = '{
        '{ROW_REQ, CMD_POP,  32'h0000_0000, 1'b1, '{STAT_EMPTY, 32'h0, 32'h0, 9'd0}},
        '{ROW_REQ, CMD_PUSH, 32'h7FFF_FFFF, 1'b1, '{STAT_OK, 32'h0, 32'h7FFF_FFFF, 9'd1}},
        '{ROW_REQ, CMD_PUSH, 32'h7FFF_FFFF, 1'b1, '{STAT_OK, 32'h0, 32'h7FFF_FFFF, 9'd2}},
        '{ROW_REQ, CMD_POP,  32'hFFFF_FFFF, 1'b1,
          '{STAT_OK, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 9'd1}},
        '{ROW_REQ, CMD_POP,  32'h0000_0000, 1'b1, '{STAT_OK, 32'h7FFF_FFFF, 32'h0, 9'd0}},
        '{ROW_REQ, CMD_PUSH, 32'h8000_0000, 1'b1, '{STAT_OK, 32'h0, 32'h8000_0000, 9'd1}},
        '{ROW_REQ, CMD_PUSH, 32'h8000_0000, 1'b1, '{STAT_OK, 32'h0, 32'h8000_0000, 9'd2}},
        '{ROW_REQ, CMD_PUSH, 32'h7FFF_FFFF, 1'b0, '0},
        '{ROW_REQ, CMD_PUSH, 32'hFFFF_FFFF, 1'b0, '0},
        '{ROW_REQ, CMD_PUSH, 32'h0000_0001, 1'b0, '0},
        '{ROW_REQ, CMD_POP,  32'h5555_5555, 1'b0, '0},
        // window write must empty a non-empty ring
        '{ROW_CFG, CMD_PUSH, 32'h0000_0002, 1'b0, '0},
        '{ROW_REQ, CMD_POP,  32'h0000_0000, 1'b1, '{STAT_EMPTY, 32'h0, 32'h0, 9'd0}},
        '{ROW_REQ, CMD_PUSH, 32'hFFFF_FFFD, 1'b1, '{STAT_OK, 32'h0, 32'hFFFF_FFFD, 9'd1}},
        // -3 / 2 truncates toward zero
        '{ROW_REQ, CMD_PUSH, 32'h0000_0000, 1'b1, '{STAT_OK, 32'h0, 32'hFFFF_FFFF, 9'd2}},
        '{ROW_REQ, CMD_PUSH, 32'h0000_0005, 1'b1, '{STAT_OK, 32'h0, 32'h0000_0002, 9'd2}},
        '{ROW_REQ, CMD_PUSH, 32'h0000_0006, 1'b1, '{STAT_OK, 32'h0, 32'h0000_0005, 9'd2}},
        '{ROW_REQ, CMD_POP,  32'h0000_0000, 1'b1, '{STAT_OK, 32'h5, 32'h0000_0006, 9'd1}},
        // zero window acts as one
        '{ROW_CFG, CMD_PUSH, 32'h0000_0000, 1'b0, '0},
        '{ROW_REQ, CMD_PUSH, 32'h1234_5678, 1'b1, '{STAT_OK, 32'h0, 32'h1234_5678, 9'd1}},
        '{ROW_REQ, CMD_PUSH, 32'hA5A5_A5A5, 1'b1, '{STAT_OK, 32'h0, 32'hA5A5_A5A5, 9'd1}},
        '{ROW_REQ, CMD_POP,  32'h0000_0000, 1'b1, '{STAT_OK, 32'hA5A5_A5A5, 32'h0, 9'd0}},
        // above the depth acts as the depth
        '{ROW_CFG, CMD_PUSH, 32'h0000_01FF, 1'b0, '0},
        '{ROW_REQ, CMD_PUSH, 32'h0001_0000, 1'b0, '0},
        '{ROW_REQ, CMD_POP,  32'h0000_0000, 1'b0, '0},
        '{ROW_REQ, CMD_POP,  32'h0000_0000, 1'b1, '{STAT_EMPTY, 32'h0, 32'h0, 9'd0}}
    };

    t_phase phases [NUM_PHASES] = '{
        '{32'h0000_0001,  60, 60, 1'b1, 1'b0},
        '{32'hFFFF_FE00,  40, 50, 1'b1, 1'b0},
        '{32'h0000_0003, 100, 55, 1'b1, 1'b0},
        '{32'h0000_01FF, 320, 95, 1'b1, 1'b0},
        '{32'h0000_0100, 120, 50, 1'b1, 1'b0},
        '{32'h0000_0002,  80, 50, 1'b1, 1'b0},
        '{32'h0000_0010, 230, 60, 1'b1, 1'b1},
        '{32'h0000_0007,  80, 55, 1'b0, 1'b0}
    };

    function automatic int ring_capacity();
        if (ring_win == '0) return 1;
        if (ring_win > WIN_W'(MAX_DEPTH)) return MAX_DEPTH;
        return int'(ring_win);
    endfunction

    function automatic int next_slot(input int idx);
        return (idx + 1 >= ring_capacity()) ? 0 : idx + 1;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] drop_oldest();
        logic signed [SAMPLE_W-1:0] v;
        v = ring_mem[ring_rd];
        ring_sum -= v;
        ring_rd = next_slot(ring_rd);
        ring_cnt--;
        return v;
    endfunction

    function automatic t_result predict_ring_step(input logic cmd,
                                                  input logic signed [SAMPLE_W-1:0] smp);
        t_result r;
        r = '0;
        if (cmd == CMD_PUSH) begin
            n_push++;
            if (ring_cnt >= ring_capacity()) begin
                void'(drop_oldest());
                n_overwrite++;
            end
            ring_mem[ring_wr] = smp;
            ring_sum += smp;
            ring_wr = next_slot(ring_wr);
            ring_cnt++;
        end else begin
            n_pop++;
            if (ring_cnt == 0) begin
                r.status = STAT_EMPTY;
                n_empty_pop++;
            end else begin
                r.popped = drop_oldest();
            end
        end
        r.fill = FILL_W'(ring_cnt);
        if (ring_cnt != 0) r.average = SAMPLE_W'(ring_sum / longint'(ring_cnt));
        return r;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return SAMPLE_W'($urandom_range(0, 255)) - 32'd128;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_request(input logic cmd, input logic [SAMPLE_W-1:0] smp,
                                input logic typed, input t_result typed_res);
        t_result predicted;
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= smp;
        do @(posedge i_clk); while (!s_tready);
        predicted = predict_ring_step(cmd, smp);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic apb_transfer(input logic wr, input logic [PDATA_W-1:0] wdata,
                                output logic [PDATA_W-1:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= REG_WINDOW;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_window_readback();
        logic [PDATA_W-1:0] rd;
        apb_transfer(1'b0, '0, rd);
        if (rd !== PDATA_W'(ring_win)) begin
            $error("window_length readback: expected %0d, got %0d", ring_win, rd);
            fail_count++;
        end
    endtask

    task automatic set_window(input logic [PDATA_W-1:0] value);
        logic [PDATA_W-1:0] unused;
        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        apb_transfer(1'b1, value, unused);
        ring_win = value[WIN_W-1:0];
        ring_rd  = 0;
        ring_wr  = 0;
        ring_cnt = 0;
        ring_sum = 0;
        n_windows++;
        check_window_readback();
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT);
        $display("status: fail");
        $finish;
    end

    // result side: random stall bursts, plus one long hold on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_asked != hold_done) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
                hold_done++;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12) - 1) @(negedge i_clk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: tuser %h tdata %h", m_tuser, m_tdata);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tuser[0] !== want.status) begin
                    $error("status mismatch: expected %0d, got %0d", want.status, m_tuser[0]);
                    fail_count++;
                end
                if (m_tdata[31:0] !== want.popped) begin
                    $error("popped_value: expected %h, got %h", want.popped, m_tdata[31:0]);
                    fail_count++;
                end
                if (m_tdata[63:32] !== want.average) begin
                    $error("average: expected %h, got %h", want.average, m_tdata[63:32]);
                    fail_count++;
                end
                if (m_tdata[72:64] !== want.fill) begin
                    $error("fill_count: expected %0d, got %0d", want.fill, m_tdata[72:64]);
                    fail_count++;
                end
                if (m_tdata[79:73] !== '0) begin
                    $error("tdata pad: expected 0, got %h", m_tdata[79:73]);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        i_rst_n    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        ring_win   = WIN_RESET;
        ring_rd    = 0;
        ring_wr    = 0;
        ring_cnt   = 0;
        ring_sum   = 0;
        fail_count = 0;
        idle_on    = 1'b1;
        hold_asked = 0;
        hold_done  = 0;
        n_windows  = 1;
        phases[6].window = {$urandom_range(0, 255) << 9} | $urandom_range(1, 40);

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        check_window_readback();

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                set_window(directed_rows[i].sample);
            end else begin
                send_request(directed_rows[i].cmd, directed_rows[i].sample,
                             directed_rows[i].typed, directed_rows[i].want);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            set_window(phases[p].window);
            idle_on = phases[p].idle;
            for (int k = 0; k < phases[p].items; k++) begin
                // output held off long enough to back the input up
                if (phases[p].squeeze && k == 20) hold_asked++;
                if (phases[p].squeeze && k == 120) drain_results();
                send_request(($urandom_range(0, 99) < phases[p].push_pct) ? CMD_PUSH : CMD_POP,
                             pick_sample(), 1'b0, '0);
            end
        end

        drain_results();
        repeat (SETTLE) @(posedge i_clk);

        $display("covered %0d pushes (%0d onto a full ring) and %0d pops (%0d on empty)",
                 n_push, n_overwrite, n_pop, n_empty_pop);
        $display("across %0d window settings, with stream gaps and a long output stall",
                 n_windows);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* sliding_window_average_queue_unit.f */
sv/swa_pkg.sv
sv/swa_fifo.sv
sv/swa_front.sv
sv/swa_div.sv
sv/swa_back.sv
sv/sliding_window_average_queue_unit.sv
test/sliding_window_average_queue_unit_test.sv
